/* hdl/lir_pkg.sv */
// shared constants and types for the linear interpolation resampler
package lir_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int STEP_W            = 18;
  localparam int FRACTION_BITS_DEF = 15;
  localparam int MAX_RESULTS       = 64;
  localparam int CNT_W             = $clog2(MAX_RESULTS + 1);
  localparam int SAMPLE_MAX        = 32767;
  localparam int SAMPLE_MIN        = -32768;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [STEP_W-1:0]    PHASE_STEP_RESET = 18'd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [STEP_W-1:0]          step_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // take the input sample
    logic prime;   // first sample, store as previous
    logic mul;     // register the interpolation product
    logic emit;    // load the output register, advance phase
    logic finish;  // drop the phase by one, move current to previous
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic primed;
    logic more;      // phase below one and result budget left
    logic out_free;  // output register can take a result this cycle
  } dp_sts_t;

endpackage

/* hdl/lir_if.sv */
// stream interfaces for the sample input and the result output
interface lir_in_if;
  logic             valid;
  logic             ready;
  lir_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface lir_out_if;
  logic             valid;
  logic             ready;
  lir_pkg::sample_t sample_out;
  logic             last_of_run;

  modport source (output valid, output sample_out, output last_of_run, input ready);
  modport sink (input valid, input sample_out, input last_of_run, output ready);
endinterface

/* hdl/lir_ctrl.sv */
// sequencing state machine of the resampler
module lir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lir_pkg::dp_sts_t  sts_i,
  output lir_pkg::dp_cmd_t  cmd_o
);
  import lir_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CHK  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.primed) begin
            cmd_o.prime = 1'b1;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (sts_i.more) begin
          cmd_o.mul = 1'b1;
          state_d   = S_EMIT;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/lir_dp.sv */
// phase, sample history, interpolation arithmetic and output register
module lir_dp #(
  parameter int FracBits = lir_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lir_pkg::sample_t  sample_in_i,
  input  lir_pkg::step_t    phase_step_i,
  input  lir_pkg::dp_cmd_t  cmd_i,
  output lir_pkg::dp_sts_t  sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lir_pkg::sample_t  sample_out_o,
  output logic              last_of_run_o
);
  import lir_pkg::*;

  localparam int PHASE_W = ((FracBits > STEP_W) ? FracBits : STEP_W) + 1;
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int PROD_W  = DIFF_W + FracBits + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam logic [PHASE_W-1:0]      ONE    = PHASE_W'(1) << FracBits;
  localparam logic [CNT_W-1:0]        CNT_MAX = CNT_W'(MAX_RESULTS);
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FracBits - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAMPLE_MIN);

  sample_t                    prev_q, cur_q;
  logic                       primed_q;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       out_valid_q;
  sample_t                    sample_out_q;
  logic                       last_q;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [FracBits:0]   frac_s;
  logic signed [SUM_W-1:0]    sum_w, shifted;
  sample_t                    result;
  logic [PHASE_W-1:0]         phase_adv;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       last_w;

  // prev*(1-f) + cur*f folded into prev + (cur-prev)*f
  assign diff   = DIFF_W'(cur_q) - DIFF_W'(prev_q);
  assign frac_s = signed'({1'b0, phase_q[FracBits-1:0]});

  always_comb begin
    sum_w   = (SUM_W'(prev_q) <<< FracBits) + SUM_W'(prod_q) + HALF;
    shifted = sum_w >>> FracBits;
    if (shifted > SAT_HI) begin
      result = sample_t'(SAT_HI[SAMPLE_W-1:0]);
    end else if (shifted < SAT_LO) begin
      result = sample_t'(SAT_LO[SAMPLE_W-1:0]);
    end else begin
      result = sample_t'(shifted[SAMPLE_W-1:0]);
    end
  end

  assign phase_adv = phase_q + PHASE_W'(phase_step_i);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign last_w    = !((phase_adv < ONE) && (cnt_inc < CNT_MAX));

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end
    if (cmd_i.emit) begin
      phase_d = phase_adv;
      cnt_d   = cnt_inc;
    end
    if (cmd_i.finish) begin
      // phase left below one after a full run saturates to one first
      phase_d = ((phase_q < ONE) ? ONE : phase_q) - ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      primed_q    <= 1'b0;
      phase_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (cmd_i.prime) begin
        prev_q   <= sample_in_i;
        primed_q <= 1'b1;
      end else if (cmd_i.finish) begin
        prev_q <= cur_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= sample_in_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(diff * frac_s);
    end
    if (cmd_i.emit) begin
      sample_out_q <= result;
      last_q       <= last_w;
    end
  end

  assign sts_o.primed   = primed_q;
  assign sts_o.more     = (phase_q < ONE) && (cnt_q < CNT_MAX);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_out_q;
  assign last_of_run_o = last_q;

endmodule

/* hdl/linear_interp_resampler.sv */
// linear interpolation sample rate converter, top level
//
//   channel  dir  handshake                  payload
//   in_i     in   valid / ready              sample_in (s16)
//   out_o    out  valid / ready              sample_out (s16), last_of_run
//   apb      in   psel, penable, pwrite      phase_step at byte address 0
//
// a priming sample is only stored as the previous sample; any other sample gives n
// results, each of which passes through the multiply stage and then the output
// register stage in turn under the state machine.
// a new sample is taken while the last result still waits in the output register.
// reset clears phase, previous sample, primed flag and restores phase_step.
// a stalled output holds the state machine before the next result is loaded.
module linear_interp_resampler #(
  parameter int FRACTION_BITS = lir_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lir_in_if.sink                           in_i,
  lir_out_if.source                        out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lir_pkg::PADDR_W-1:0]      paddr,
  input  logic [lir_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lir_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import lir_pkg::*;

  step_t   phase_step_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    reg_sel;

  // register index is the word address
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_PHASE_STEP);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(phase_step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      phase_step_q <= pwdata[STEP_W-1:0];
    end
  end

  lir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lir_dp #(
    .FracBits (FRACTION_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_in_i   (in_i.sample_in),
    .phase_step_i  (phase_step_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .sample_out_o  (out_o.sample_out),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule
